@@ rtl/utf8d_pkg.sv @@
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int PEND_W = 2;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic              emit;
    logic              done;
    logic [CP_W-1:0]   char_code;
    logic [PEND_W-1:0] bytes_pending;
    logic [CP_W-1:0]   partial_value;
  } step_t;

endpackage

@@ rtl/utf8d_step.sv @@
`timescale 1ns / 1ps

module utf8d_step (
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
  input  logic                         end_of_string,
  input  logic [utf8d_pkg::PEND_W-1:0] bytes_pending,
  input  logic [utf8d_pkg::CP_W-1:0]   partial_value,
  output utf8d_pkg::step_t             res
);

  always_comb begin
    logic [utf8d_pkg::PEND_W-1:0] pend_dec;
    logic [utf8d_pkg::CP_W-1:0]   shifted;
    pend_dec = bytes_pending - utf8d_pkg::PEND_ONE;
    shifted  = {partial_value[utf8d_pkg::CP_W-7:0], byte_in[5:0]};

    res.emit          = 1'b0;
    res.done          = end_of_string;
    res.char_code     = utf8d_pkg::REPLACEMENT;
    res.bytes_pending = bytes_pending;
    res.partial_value = partial_value;

    if (bytes_pending == utf8d_pkg::PEND_NONE) begin
      if (byte_in inside {[8'h00:8'h7F]}) begin
        res.emit      = 1'b1;
        res.char_code = {14'd0, byte_in[6:0]};
      end else if (byte_in inside {[8'hC0:8'hDF]}) begin
        res.bytes_pending = utf8d_pkg::PEND_ONE;
        res.partial_value = {16'd0, byte_in[4:0]};
      end else if (byte_in inside {[8'hE0:8'hEF]}) begin
        res.bytes_pending = utf8d_pkg::PEND_TWO;
        res.partial_value = {17'd0, byte_in[3:0]};
      end else if (byte_in inside {[8'hF0:8'hF7]}) begin
        res.bytes_pending = utf8d_pkg::PEND_THREE;
        res.partial_value = {18'd0, byte_in[2:0]};
      end else begin
        res.emit = 1'b1;
      end
    end else begin
      res.bytes_pending = pend_dec;
      res.partial_value = shifted;
      if (pend_dec == utf8d_pkg::PEND_NONE) begin
        res.emit          = 1'b1;
        res.char_code     = shifted;
        res.partial_value = '0;
      end
    end

    // A string that ends inside a sequence gives one replacement and starts afresh.
    if (!res.emit && end_of_string) begin
      res.emit          = 1'b1;
      res.char_code     = utf8d_pkg::REPLACEMENT;
      res.bytes_pending = utf8d_pkg::PEND_NONE;
      res.partial_value = '0;
    end
  end

endmodule

@@ rtl/utf8d_out_reg.sv @@
`timescale 1ns / 1ps

module utf8d_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  utf8d_pkg::step_t           res,
  input  logic                       cp_ready,
  output logic                       cp_valid,
  output logic [utf8d_pkg::CP_W-1:0] char_code,
  output logic                       string_done
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (load) begin
      cp_valid <= 1'b1;
    end else if (cp_ready) begin
      cp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_code   <= res.char_code;
      string_done <= res.done;
    end
  end

endmodule

@@ rtl/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps

// Byte-serial UTF-8 to UTF-32 decoder. It takes one byte an item, with a flag on the last
// byte of each string, and gives one code point for each completed sequence, for each bad
// lead byte, and for a sequence that the end of the string cuts short (U+FFFD for the last
// two). Continuation bytes are not checked and overlong forms pass. A byte is accepted in
// every cycle unless the input stalls: it is held in an input register, decoded against the
// pending-byte count and the partial value, and its result lands in the output register
// once that register has space. The input stalls only while the output register holds a
// result that has not been taken and the byte in the input register would produce another.
module utf8_stream_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_ready,
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
  input  logic                         end_of_string,
  output logic                         cp_valid,
  input  logic                         cp_ready,
  output logic [utf8d_pkg::CP_W-1:0]   char_code,
  output logic                         string_done
);

  logic                         in_valid;
  logic [utf8d_pkg::BYTE_W-1:0] in_byte;
  logic                         in_eos;
  logic [utf8d_pkg::PEND_W-1:0] bytes_pending;
  logic [utf8d_pkg::CP_W-1:0]   partial_value;
  utf8d_pkg::step_t             res;
  logic                         out_space;
  logic                         advance;

  utf8d_step u_step (
    .byte_in       (in_byte),
    .end_of_string (in_eos),
    .bytes_pending (bytes_pending),
    .partial_value (partial_value),
    .res           (res)
  );

  assign out_space  = !cp_valid || cp_ready;
  assign advance    = in_valid && (!res.emit || out_space);
  assign byte_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      bytes_pending <= utf8d_pkg::PEND_NONE;
      partial_value <= '0;
    end else begin
      if (byte_ready) begin
        in_valid <= byte_valid;
      end
      if (advance) begin
        bytes_pending <= res.bytes_pending;
        partial_value <= res.partial_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready) begin
      in_byte <= byte_in;
      in_eos  <= end_of_string;
    end
  end

  utf8d_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && res.emit),
    .res         (res),
    .cp_ready    (cp_ready),
    .cp_valid    (cp_valid),
    .char_code   (char_code),
    .string_done (string_done)
  );

endmodule

@@ rtl/utf8d_checker.sv @@
`timescale 1ns / 1ps

module utf8d_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         byte_valid,
  input logic                         byte_ready,
  input logic                         cp_valid,
  input logic                         cp_ready,
  input logic [utf8d_pkg::CP_W-1:0]   char_code,
  input logic                         string_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !cp_valid)
    else $error("Output valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    cp_valid && !cp_ready |=> cp_valid && $stable(char_code) && $stable(string_done))
    else $error("Stalled item changed.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> cp_valid && !cp_ready)
    else $error("Input stalled with the output free.");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(cp_valid) |-> $past(byte_valid && byte_ready && !rst, 2))
    else $error("Result without an accepted byte.");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_ready  (byte_ready),
  .cp_valid    (cp_valid),
  .cp_ready    (cp_ready),
  .char_code   (char_code),
  .string_done (string_done)
);
